FILE: rtl/upqdk_pkg.sv
// shared types and constants of the priority queue with decrease-key
// used by upqdk_cell and unsorted_priority_queue_decrease_key
`default_nettype none

package upqdk_pkg;

  localparam int unsigned ID_W         = 16;
  localparam int unsigned PRI_W        = 16;
  localparam int unsigned COUNT_OUT_W  = 7;
  localparam int unsigned CAPACITY_DEF = 64;

  // request codes as they arrive on req_type_i
  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_PROCESS = 2'd1,
    REQ_UPGRADE = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_NOT_URGENT = 3'd3,
    ST_FULL       = 3'd4
  } status_e;

  // operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_START,
    OP_SCAN,
    OP_MOVE
  } cell_op_e;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  typedef struct packed {
    cell_op_e         op;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } cell_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
  } cell_flag_t;

endpackage

`default_nettype wire

FILE: rtl/unsorted_priority_queue_decrease_key.sv
// top level of the min-priority queue with decrease-key on a chain of cells
// depends on upqdk_pkg and upqdk_cell
`default_nettype none

// Usage
//   A request (req_type_i, patient_id_i, priority_req_i) is taken at a rising
//   edge with start high and busy low. Exactly one result follows per request:
//   status, served entry, current front and entry count, shown for one cycle
//   while done_o is high. The receiver cannot hold results off.
//   Entries live in a row of CAPACITY cells kept sorted by priority and then
//   by insertion rank, so the front is always cell 0. Every cell compares
//   itself with the request and takes its own or a neighbor's value at once.
//   Insert, process and clear: executed in S_EXEC with the result shown in S_DONE,
//   and a new request may be taken in the done cycle.
//   Upgrade: a search token walks the chain one cell per cycle until the first
//   cell with the id (or the end of the held entries), then S_MOVE moves the
//   entry.
//   Reset empties the queue and needs no clearing pass; cells past the count
//   are never read.

module unsorted_priority_queue_decrease_key import upqdk_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             req_type_i,
  input  wire logic [ID_W-1:0]        patient_id_i,
  input  wire logic [PRI_W-1:0]       priority_req_i,
  output logic                        done_o,
  output logic [2:0]                  status_o,
  output logic [ID_W-1:0]             served_id_o,
  output logic [PRI_W-1:0]            served_priority_o,
  output logic                        front_valid_o,
  output logic [ID_W-1:0]             front_id_o,
  output logic [PRI_W-1:0]            front_priority_o,
  output logic [COUNT_OUT_W-1:0]      entry_count_o
);

  localparam int unsigned RANK_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY+1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_MOVE,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  req_e              req_q, req_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [PRI_W-1:0]  pri_q, pri_d;
  status_e           status_q, status_d;
  logic [ID_W-1:0]   sid_q, sid_d;
  logic [PRI_W-1:0]  spri_q, spri_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [PRI_W-1:0]  tpri_q, tpri_d;
  logic [RANK_W-1:0] trank_q, trank_d;

  cell_cmd_t         cmd;
  logic [RANK_W-1:0] rank_new;

  // chain wiring, one element per cell
  entry_t            ent_a  [CAPACITY];
  logic [RANK_W-1:0] rank_a [CAPACITY];
  cell_flag_t        flag_a [CAPACITY];
  logic [CAPACITY-1:0] gt_v;
  logic [CAPACITY-1:0] fwd_v;
  logic [CAPACITY-1:0] hit_v;
  logic [CAPACITY-1:0] miss_v;

  logic              any_hit;
  logic              any_miss;
  logic [PRI_W-1:0]  sel_pri;
  logic [RANK_W-1:0] sel_rank;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t            left_ent;
    logic [RANK_W-1:0] left_rank;
    logic              left_gt;
    logic              left_fwd;
    entry_t            right_ent;
    logic [RANK_W-1:0] right_rank;

    if (i == 0) begin : g_head
      assign left_ent  = '0;
      assign left_rank = '0;
      assign left_gt   = 1'b0;
      assign left_fwd  = 1'b0;
    end else begin : g_mid
      assign left_ent  = ent_a[i-1];
      assign left_rank = rank_a[i-1];
      assign left_gt   = gt_v[i-1];
      assign left_fwd  = fwd_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_ent  = '0;
      assign right_rank = '0;
    end else begin : g_body
      assign right_ent  = ent_a[i+1];
      assign right_rank = rank_a[i+1];
    end

    upqdk_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .rank_new_i   (rank_new),
      .pop_rank_i   (rank_a[0]),
      .count_i      (count_q),
      .left_ent_i   (left_ent),
      .left_rank_i  (left_rank),
      .left_gt_i    (left_gt),
      .left_fwd_i   (left_fwd),
      .right_ent_i  (right_ent),
      .right_rank_i (right_rank),
      .ent_o        (ent_a[i]),
      .rank_o       (rank_a[i]),
      .gt_o         (gt_v[i]),
      .fwd_o        (fwd_v[i]),
      .flag_o       (flag_a[i])
    );

    assign hit_v[i]  = flag_a[i].hit;
    assign miss_v[i] = flag_a[i].miss;
  end

  assign any_hit  = |hit_v;
  assign any_miss = |miss_v;

  // at most one cell hits, so an and-or picks the target key
  always_comb begin
    sel_pri  = '0;
    sel_rank = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_pri  = sel_pri  | (hit_v[i] ? ent_a[i].pri : '0);
      sel_rank = sel_rank | (hit_v[i] ? rank_a[i]    : '0);
    end
  end

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    id_d     = id_q;
    pri_d    = pri_q;
    status_d = status_q;
    sid_d    = sid_q;
    spri_d   = spri_q;
    count_d  = count_q;
    tpri_d   = tpri_q;
    trank_d  = trank_q;
    cmd      = '{op: OP_HOLD, id: id_q, pri: pri_q};
    rank_new = count_q[RANK_W-1:0];

    unique case (state_q)
      S_IDLE, S_DONE: begin
        if (start) begin
          req_d   = req_e'(req_type_i);
          id_d    = patient_id_i;
          pri_d   = priority_req_i;
          state_d = S_EXEC;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EXEC: begin
        status_d = ST_OK;
        sid_d    = '0;
        spri_d   = '0;
        state_d  = S_DONE;
        unique case (req_q)
          REQ_INSERT: begin
            if (count_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
            end else begin
              cmd.op  = OP_INSERT;
              count_d = count_q + CNT_W'(1);
            end
          end
          REQ_PROCESS: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              cmd.op  = OP_POP;
              sid_d   = ent_a[0].id;
              spri_d  = ent_a[0].pri;
              count_d = count_q - CNT_W'(1);
            end
          end
          REQ_UPGRADE: begin
            cmd.op  = OP_START;
            state_d = S_SCAN;
          end
          REQ_CLEAR: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (any_hit) begin
          tpri_d  = sel_pri;
          trank_d = sel_rank;
          state_d = S_MOVE;
        end else if (any_miss) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end
      end
      S_MOVE: begin
        // only a strictly more urgent value moves the entry toward the front
        rank_new = trank_q;
        if (pri_q < tpri_q) begin
          cmd.op = OP_MOVE;
        end else begin
          status_d = ST_NOT_URGENT;
        end
        state_d = S_DONE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      status_q <= ST_OK;
      req_q    <= REQ_INSERT;
      id_q     <= '0;
      pri_q    <= '0;
      sid_q    <= '0;
      spri_q   <= '0;
      tpri_q   <= '0;
      trank_q  <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      status_q <= status_d;
      req_q    <= req_d;
      id_q     <= id_d;
      pri_q    <= pri_d;
      sid_q    <= sid_d;
      spri_q   <= spri_d;
      tpri_q   <= tpri_d;
      trank_q  <= trank_d;
    end
  end

  assign busy              = (state_q == S_EXEC) || (state_q == S_SCAN) ||
                             (state_q == S_MOVE);
  assign done_o            = state_q == S_DONE;
  assign status_o          = status_q;
  assign served_id_o       = sid_q;
  assign served_priority_o = spri_q;
  assign front_valid_o     = count_q != '0;
  assign front_id_o        = front_valid_o ? ent_a[0].id  : '0;
  assign front_priority_o  = front_valid_o ? ent_a[0].pri : '0;
  assign entry_count_o     = COUNT_OUT_W'(count_q);

  // a result never lasts more than one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // the search token hits at most one cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> $onehot0(hit_v))
    else $error("more than one cell claims the search token");

  // chain stays sorted at the front
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (count_q > CNT_W'(1))) |-> (ent_a[0].pri <= ent_a[1].pri))
    else $error("front cells out of priority order");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_q == ST_FULL)) |-> (count_q == CNT_W'(CAPACITY)))
    else $error("full status while the queue has room");

endmodule

`default_nettype wire

FILE: rtl/upqdk_cell.sv
// one cell of the sorted entry chain: id, priority and insertion rank
// depends on upqdk_pkg
`default_nettype none

module upqdk_cell import upqdk_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned IDX      = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cell_cmd_t                     cmd_i,
  input  wire logic [$clog2(CAPACITY)-1:0]   rank_new_i,
  input  wire logic [$clog2(CAPACITY)-1:0]   pop_rank_i,
  input  wire logic [$clog2(CAPACITY+1)-1:0] count_i,
  input  wire entry_t                        left_ent_i,
  input  wire logic [$clog2(CAPACITY)-1:0]   left_rank_i,
  input  wire logic                          left_gt_i,
  input  wire logic                          left_fwd_i,
  input  wire entry_t                        right_ent_i,
  input  wire logic [$clog2(CAPACITY)-1:0]   right_rank_i,
  output entry_t                             ent_o,
  output logic [$clog2(CAPACITY)-1:0]        rank_o,
  output logic                               gt_o,
  output logic                               fwd_o,
  output cell_flag_t                         flag_o
);

  localparam int unsigned RANK_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY+1);
  localparam bit          LAST   = (IDX == CAPACITY - 1);

  entry_t            ent_q, ent_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic              tok_q, tok_d;
  logic              trail_q, trail_d;

  logic valid;
  logic match;
  logic key_gt;
  logic gt;
  logic hit;
  logic miss;
  logic fwd;

  assign valid  = CNT_W'(IDX) < count_i;
  assign match  = ent_q.id == cmd_i.id;
  assign key_gt = (ent_q.pri > cmd_i.pri) ||
                  ((ent_q.pri == cmd_i.pri) && (rank_q > rank_new_i));

  always_comb begin
    gt   = 1'b0;
    hit  = 1'b0;
    miss = 1'b0;
    fwd  = 1'b0;
    unique case (cmd_i.op)
      OP_INSERT: gt = !valid || (ent_q.pri > cmd_i.pri);
      OP_MOVE:   gt = trail_q && valid && key_gt;
      OP_SCAN: begin
        hit  = tok_q && valid && match;
        miss = tok_q && (!valid || (LAST && !match));
        fwd  = tok_q && valid && !match && !LAST;
      end
      default: gt = 1'b0;
    endcase
  end

  always_comb begin
    ent_d   = ent_q;
    rank_d  = rank_q;
    tok_d   = tok_q;
    trail_d = trail_q;
    unique case (cmd_i.op)
      OP_INSERT, OP_MOVE: begin
        if (gt) begin
          if (left_gt_i) begin
            ent_d  = left_ent_i;
            rank_d = left_rank_i;
          end else begin
            ent_d  = '{id: cmd_i.id, pri: cmd_i.pri};
            rank_d = rank_new_i;
          end
        end
      end
      OP_POP: begin
        ent_d  = right_ent_i;
        rank_d = (right_rank_i > pop_rank_i) ? right_rank_i - RANK_W'(1) : right_rank_i;
      end
      OP_START: begin
        tok_d   = (IDX == 0);
        trail_d = (IDX == 0);
      end
      OP_SCAN: begin
        tok_d   = left_fwd_i || hit;
        trail_d = trail_q || left_fwd_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= 1'b0;
      trail_q <= 1'b0;
    end else begin
      tok_q   <= tok_d;
      trail_q <= trail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    rank_q <= rank_d;
  end

  assign ent_o  = ent_q;
  assign rank_o = rank_q;
  assign gt_o   = gt;
  assign fwd_o  = fwd;
  assign flag_o = '{hit: hit, miss: miss};

endmodule

`default_nettype wire

FILE: tb/sv/unsorted_priority_queue_decrease_key_test.sv
`timescale 1ns / 1ps
// self-checking test of the min-priority queue with decrease-key: directed then random
// requests, every result predicted by a scoreboard class and compared field by field
// depends on upqdk_pkg and unsorted_priority_queue_decrease_key

module unsorted_priority_queue_decrease_key_test
  import upqdk_pkg::*;
();

  // one result as the block shows it while done_o is high
  typedef struct {
    logic [2:0]             status;
    logic [ID_W-1:0]        served_id;
    logic [PRI_W-1:0]       served_priority;
    logic                   front_valid;
    logic [ID_W-1:0]        front_id;
    logic [PRI_W-1:0]       front_priority;
    logic [COUNT_OUT_W-1:0] entry_count;
  } outcome_t;

  class queue_scoreboard;
    int unsigned capacity;
    entry_t      held_entries[$];
    outcome_t    expected_outcomes[$];
    int unsigned mismatches;
    int unsigned req_tally[4];
    int unsigned status_tally[5];

    function new(int unsigned cap);
      capacity = cap;
      mismatches = 0;
      foreach (req_tally[i]) req_tally[i] = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    // lowest priority value, earliest held among ties
    function int most_urgent_index();
      int best;
      int i;
      best = 0;
      for (i = 1; i < held_entries.size(); i++) begin
        if (held_entries[i].pri < held_entries[best].pri) best = i;
      end
      return best;
    endfunction

    function void note_request(req_e req, logic [ID_W-1:0] req_id,
                               logic [PRI_W-1:0] req_pri);
      outcome_t want;
      int       k;
      int       i;
      want.status = ST_OK;
      want.served_id = '0;
      want.served_priority = '0;
      want.front_valid = 1'b0;
      want.front_id = '0;
      want.front_priority = '0;
      req_tally[req]++;
      case (req)
        REQ_INSERT: begin
          if (held_entries.size() >= capacity) want.status = ST_FULL;
          else held_entries.push_back('{id: req_id, pri: req_pri});
        end
        REQ_PROCESS: begin
          if (held_entries.size() == 0) begin
            want.status = ST_EMPTY;
          end else begin
            k = most_urgent_index();
            want.served_id = held_entries[k].id;
            want.served_priority = held_entries[k].pri;
            held_entries.delete(k);
          end
        end
        REQ_UPGRADE: begin
          k = -1;
          for (i = 0; i < held_entries.size(); i++) begin
            if (held_entries[i].id == req_id &&
                (k < 0 || held_entries[i].pri < held_entries[k].pri)) k = i;
          end
          if (k < 0) want.status = ST_NOT_FOUND;
          else if (held_entries[k].pri > req_pri) held_entries[k].pri = req_pri;
          else want.status = ST_NOT_URGENT;
        end
        default: held_entries.delete();
      endcase
      if (held_entries.size() > 0) begin
        k = most_urgent_index();
        want.front_valid = 1'b1;
        want.front_id = held_entries[k].id;
        want.front_priority = held_entries[k].pri;
      end
      want.entry_count = COUNT_OUT_W'(held_entries.size());
      status_tally[want.status]++;
      expected_outcomes.push_back(want);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, what);
      if (mismatches == 100) $display("further mismatches counted but not shown");
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        report($sformatf("result with no request outstanding, status %0d", got.status));
        return;
      end
      want = expected_outcomes.pop_front();
      compare_field("status", 16'(got.status), 16'(want.status));
      compare_field("served_id", got.served_id, want.served_id);
      compare_field("served_priority", got.served_priority, want.served_priority);
      compare_field("front_valid", 16'(got.front_valid), 16'(want.front_valid));
      compare_field("front_id", got.front_id, want.front_id);
      compare_field("front_priority", got.front_priority, want.front_priority);
      compare_field("entry_count", 16'(got.entry_count), 16'(want.entry_count));
    endtask
  endclass

  localparam int unsigned CAPACITY        = CAPACITY_DEF;
  localparam int          ITEMS_PER_PHASE = 250;
  // the longest upgrade finds its id in the last cell
  localparam int          DRAIN_CYCLES    = 80;
  // longest quiet stretch tolerated: worst upgrade plus a very long sender gap
  localparam int          WATCHDOG_LIMIT  = 2000;

  // request mixes; the random part rotates through them so the queue
  // swings between empty and full
  typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [1:0]             req_type_i;
  logic [ID_W-1:0]        patient_id_i;
  logic [PRI_W-1:0]       priority_req_i;
  logic                   done_o;
  logic [2:0]             status_o;
  logic [ID_W-1:0]        served_id_o;
  logic [PRI_W-1:0]       served_priority_o;
  logic                   front_valid_o;
  logic [ID_W-1:0]        front_id_o;
  logic [PRI_W-1:0]       front_priority_o;
  logic [COUNT_OUT_W-1:0] entry_count_o;

  queue_scoreboard sb;
  outcome_t        seen;
  int              quiet_cycles = 0;

  unsorted_priority_queue_decrease_key #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .patient_id_i     (patient_id_i),
    .priority_req_i   (priority_req_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .served_id_o      (served_id_o),
    .served_priority_o(served_priority_o),
    .front_valid_o    (front_valid_o),
    .front_id_o       (front_id_o),
    .front_priority_o (front_priority_o),
    .entry_count_o    (entry_count_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // result monitor: a result is valid for exactly one cycle, so it is
  // taken at the rising edge that closes that cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      seen.status = status_o;
      seen.served_id = served_id_o;
      seen.served_priority = served_priority_o;
      seen.front_valid = front_valid_o;
      seen.front_id = front_id_o;
      seen.front_priority = front_priority_o;
      seen.entry_count = entry_count_o;
      sb.check_result(seen);
    end
  end

  // watchdog: any accepted request or any result counts as progress
  always @(posedge clk_i) begin
    if ((rst_ni && start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no request taken and no result for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // drives one request from a falling edge; holds it until the block takes it
  // and returns at the falling edge after acceptance with start still high
  task automatic issue_request(req_e req, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri,
                               int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    req_type_i = req;
    patient_id_i = id;
    priority_req_i = pri;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(req, id, pri);
    @(negedge clk_i);
  endtask

  // sender holds off until every outstanding result is back
  task automatic await_drain();
    start = 1'b0;
    while (sb.expected_outcomes.size() != 0) @(negedge clk_i);
  endtask

  // few distinct ids so upgrades hit duplicates, full-range ids now and then
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(99) < 30) return ID_W'($urandom());
    return ID_W'($urandom_range(11));
  endfunction

  // narrow band for plenty of ties, plus both extremes and full range
  function automatic logic [PRI_W-1:0] pick_priority();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return PRI_W'($urandom_range(40));
    if (roll < 75) return PRI_W'($urandom());
    if (roll < 87) return '0;
    return '1;
  endfunction

  task automatic pick_request(mix_e mix, output req_e req, output logic [ID_W-1:0] id,
                              output logic [PRI_W-1:0] pri);
    int     roll;
    int     ins_pct;
    int     proc_pct;
    int     upg_pct;
    entry_t target;
    case (mix)
      MIX_FILL: begin
        ins_pct = 84; proc_pct = 6; upg_pct = 10;
      end
      MIX_BALANCED: begin
        ins_pct = 35; proc_pct = 30; upg_pct = 34;
      end
      default: begin
        ins_pct = 15; proc_pct = 70; upg_pct = 13;
      end
    endcase
    // ids and priorities are random on process and clear too, the block ignores them
    id = pick_id();
    pri = pick_priority();
    roll = $urandom_range(99);
    if (roll < ins_pct) begin
      req = REQ_INSERT;
    end else if (roll < ins_pct + proc_pct) begin
      req = REQ_PROCESS;
    end else if (roll < ins_pct + proc_pct + upg_pct) begin
      req = REQ_UPGRADE;
      // mostly aim at a held entry so the search actually finds something
      if (sb.held_entries.size() > 0 && $urandom_range(99) < 75) begin
        target = sb.held_entries[$urandom_range(sb.held_entries.size() - 1)];
        id = target.id;
        roll = $urandom_range(99);
        if (roll < 60 && target.pri != 0) pri = PRI_W'($urandom_range(target.pri - 1));
        else if (roll < 80) pri = target.pri;
      end
    end else begin
      req = REQ_CLEAR;
    end
  endtask

  task automatic run_directed();
    // empty queue corner cases
    issue_request(REQ_PROCESS, 16'h0000, 16'h0000, 0);
    issue_request(REQ_UPGRADE, 16'h0042, 16'h0001, 0);
    issue_request(REQ_CLEAR,   16'hFFFF, 16'hFFFF, 0);
    // field extremes and a duplicate id with equal priority
    issue_request(REQ_INSERT,  16'hFFFF, 16'hFFFF, 0);
    issue_request(REQ_INSERT,  16'h0000, 16'h0000, 0);
    issue_request(REQ_INSERT,  16'h1234, 16'h0005, 0);
    issue_request(REQ_INSERT,  16'h1234, 16'h0005, 0);
    issue_request(REQ_INSERT,  16'h0042, 16'h8000, 0);
    // upgrade refused for equal and for higher priority
    issue_request(REQ_UPGRADE, 16'h1234, 16'h0005, 0);
    issue_request(REQ_UPGRADE, 16'h1234, 16'h0009, 0);
    // upgrade of the earlier of two equal entries with the id
    issue_request(REQ_UPGRADE, 16'h1234, 16'h0003, 0);
    issue_request(REQ_UPGRADE, 16'hBEEF, 16'h0000, 0);
    // tie at zero priority: the entry held longer goes to the front
    issue_request(REQ_UPGRADE, 16'hFFFF, 16'h0000, 0);
    issue_request(REQ_UPGRADE, 16'h0042, 16'h7FFF, 0);
    issue_request(REQ_PROCESS, 16'hFFFF, 16'hFFFF, 0);
    issue_request(REQ_PROCESS, 16'h0000, 16'h0000, 0);
    issue_request(REQ_PROCESS, 16'h5A5A, 16'hA5A5, 0);
    issue_request(REQ_INSERT,  16'h5555, 16'hAAAA, 0);
    issue_request(REQ_CLEAR,   16'h0000, 16'h0000, 0);
    issue_request(REQ_PROCESS, 16'h0000, 16'h0000, 0);
  endtask

  initial begin
    int                phase;
    int                issued;
    int                burst;
    int                idle_pct;
    mix_e              mix;
    req_e              req;
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;

    sb = new(CAPACITY);
    start = 1'b0;
    req_type_i = REQ_INSERT;
    patient_id_i = '0;
    priority_req_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();
    await_drain();

    // three phases: sender idles often, then mostly, then never
    mix = MIX_FILL;
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 25 : (phase == 1) ? 83 : 0;
      issued = 0;
      while (issued < ITEMS_PER_PHASE) begin
        burst = $urandom_range(60, 130);
        while (burst > 0 && issued < ITEMS_PER_PHASE) begin
          pick_request(mix, req, id, pri);
          issue_request(req, id, pri, idle_pct);
          issued++;
          burst--;
          // occasional full drain in the middle of traffic
          if ($urandom_range(199) == 0) await_drain();
        end
        case (mix)
          MIX_FILL:     mix = MIX_BALANCED;
          MIX_BALANCED: mix = MIX_DRAIN;
          default:      mix = MIX_FILL;
        endcase
      end
      await_drain();
    end

    // quiet tail catches any stray result
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d requests: %0d insert, %0d process, %0d upgrade, %0d clear",
             sb.req_tally[0] + sb.req_tally[1] + sb.req_tally[2] + sb.req_tally[3],
             sb.req_tally[REQ_INSERT], sb.req_tally[REQ_PROCESS],
             sb.req_tally[REQ_UPGRADE], sb.req_tally[REQ_CLEAR]);
    $display("outcomes: %0d ok, %0d empty, %0d id absent, %0d not more urgent, %0d full",
             sb.status_tally[ST_OK], sb.status_tally[ST_EMPTY],
             sb.status_tally[ST_NOT_FOUND], sb.status_tally[ST_NOT_URGENT],
             sb.status_tally[ST_FULL]);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
